### rtl/i2c_display_byte_writer_assert.svh
// Assertion macros for the display byte writer.
// Included by the top level; no other dependencies.
`ifndef I2C_DISPLAY_BYTE_WRITER_ASSERT_SVH
`define I2C_DISPLAY_BYTE_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check, disabled while reset is asserted
`define IDBW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also runs during reset
`define IDBW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define IDBW_ASSERT(lbl, clk, rst_n, prop, msg)
`define IDBW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/idbw_pkg.sv
// Shared types and constants for the display byte writer.
// No dependencies.
package idbw_pkg;

  // Control bytes that follow the address byte
  localparam logic [7:0] CTRL_DATA = 8'h40;
  localparam logic [7:0] CTRL_CMD  = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS    = 2'd0;
  localparam logic [1:0] REG_ACK_TIMEOUT       = 2'd1;
  localparam logic [1:0] REG_HALF_PERIOD_TICKS = 2'd2;

  // Register reset values
  localparam logic [7:0] DEVICE_ADDRESS_RST    = 8'h78;
  localparam logic [7:0] ACK_TIMEOUT_RST       = 8'd250;
  localparam logic [7:0] HALF_PERIOD_TICKS_RST = 8'd1;

  // Sequencer phases
  localparam logic [3:0] PH_IDLE     = 4'd0;
  localparam logic [3:0] PH_ST_A     = 4'd1;
  localparam logic [3:0] PH_ST_B     = 4'd2;
  localparam logic [3:0] PH_ST_C     = 4'd3;
  localparam logic [3:0] PH_BIT_A    = 4'd4;
  localparam logic [3:0] PH_BIT_B    = 4'd5;
  localparam logic [3:0] PH_BIT_C    = 4'd6;
  localparam logic [3:0] PH_ACK_A    = 4'd7;
  localparam logic [3:0] PH_ACK_B    = 4'd8;
  localparam logic [3:0] PH_ACK_POLL = 4'd9;
  localparam logic [3:0] PH_SP_A     = 4'd10;
  localparam logic [3:0] PH_SP_B     = 4'd11;
  localparam logic [3:0] PH_SP_C     = 4'd12;
  localparam logic [3:0] PH_SP_END   = 4'd13;

  // Last byte slot: every byte sent, final STOP pending
  localparam logic [1:0] SLOT_STOP = 2'd3;

  // One result item
  typedef struct packed {
    logic scl_level;
    logic sda_level;
    logic busy_res;
    logic ack_missed;
    logic done_res;
    logic rejected;
  } res_t;

endpackage

### rtl/i2c_display_byte_writer.sv
// Write-only I2C master for a display: one byte per transaction.
// Depends on idbw_pkg and i2c_display_byte_writer_assert.svh.
//
// Each send request while idle arms one I2C write: START, device address,
// control byte (0x40 data, 0x00 command), payload, STOP. Tick items move the
// pin sequence one step, or count down one delay tick; pin drives and status
// come back as one result per item. The sequencer state is updated and the
// result registered at the edge that accepts the item, and the next item is
// taken in the following cycle unless stalled. The output register decouples the
// two sides; input stalls only while a result waits and the output is stalled.
// A missed acknowledge (SDA high for more than ack_timeout polls) issues a STOP,
// sets the sticky ack_missed flag and carries on with the next byte.
// Configuration writes are always accepted and apply from the next item.
`include "i2c_display_byte_writer_assert.svh"

module i2c_display_byte_writer
  import idbw_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_req_type,
  input  logic [7:0] in_payload,
  input  logic       in_is_data,
  input  logic       in_sda_sample,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_level,
  output logic       out_sda_level,
  output logic       out_busy_res,
  output logic       out_ack_missed,
  output logic       out_done_res,
  output logic       out_rejected,
  // configuration channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers
  logic [7:0] device_address_r, ack_timeout_r, half_period_ticks_r;

  // Sequencer state
  logic [3:0] phase_r, phase_nxt;
  logic [1:0] byte_slot_r, byte_slot_nxt;
  logic [3:0] bit_count_r, bit_count_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic [7:0] held_payload_r, held_payload_nxt;
  logic       held_kind_r, held_kind_nxt;
  logic [7:0] delay_count_r, delay_count_nxt;
  logic [7:0] poll_count_r, poll_count_nxt;
  logic       miss_flag_r, miss_flag_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;

  // Output register
  logic       out_valid_r, out_valid_nxt;
  res_t       res_r, res_nxt;

  logic       in_acc;
  logic       done;
  logic       rej;
  logic [7:0] delay_start;
  logic [3:0] bit_inc;

  // Next-byte step shared by acknowledge and STOP
  logic [1:0] nb_slot;
  logic [7:0] nb_shift;
  logic [3:0] nb_bit;
  logic [3:0] nb_phase;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;

  // Zero half period counts as one tick
  assign delay_start = (half_period_ticks_r == 8'd0) ? 8'd0 : half_period_ticks_r - 8'd1;
  assign bit_inc     = bit_count_r + 4'd1;

  always_comb begin
    if (byte_slot_r < 2'd2) begin
      nb_slot  = byte_slot_r + 2'd1;
      nb_shift = (byte_slot_r == 2'd0) ? (held_kind_r ? CTRL_DATA : CTRL_CMD)
                                       : held_payload_r;
      nb_bit   = 4'd0;
      nb_phase = PH_BIT_A;
    end else begin
      nb_slot  = SLOT_STOP;
      nb_shift = shift_byte_r;
      nb_bit   = bit_count_r;
      nb_phase = PH_SP_A;
    end
  end

  // Sequencer step for the accepted item
  always_comb begin
    phase_nxt        = phase_r;
    byte_slot_nxt    = byte_slot_r;
    bit_count_nxt    = bit_count_r;
    shift_byte_nxt   = shift_byte_r;
    held_payload_nxt = held_payload_r;
    held_kind_nxt    = held_kind_r;
    delay_count_nxt  = delay_count_r;
    poll_count_nxt   = poll_count_r;
    miss_flag_nxt    = miss_flag_r;
    scl_nxt          = scl_r;
    sda_nxt          = sda_r;
    done             = 1'b0;
    rej              = 1'b0;

    if (in_acc) begin
      if (!in_req_type) begin
        if (phase_r != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          held_payload_nxt = in_payload;
          held_kind_nxt    = in_is_data;
          miss_flag_nxt    = 1'b0;
          byte_slot_nxt    = 2'd0;
          bit_count_nxt    = 4'd0;
          shift_byte_nxt   = device_address_r;
          delay_count_nxt  = 8'd0;
          poll_count_nxt   = 8'd0;
          phase_nxt        = PH_ST_A;
        end
      end else if (phase_r != PH_IDLE) begin
        if (delay_count_r != 8'd0) begin
          delay_count_nxt = delay_count_r - 8'd1;
        end else begin
          unique case (phase_r)
            PH_ST_A: begin
              sda_nxt = 1'b1;
              scl_nxt = 1'b1;
              delay_count_nxt = delay_start;
              phase_nxt = PH_ST_B;
            end
            PH_ST_B: begin
              sda_nxt = 1'b0;
              delay_count_nxt = delay_start;
              phase_nxt = PH_ST_C;
            end
            PH_ST_C: begin
              scl_nxt = 1'b0;
              phase_nxt = PH_BIT_A;
            end
            PH_BIT_A: begin
              sda_nxt = shift_byte_r[7];
              shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
              phase_nxt = PH_BIT_B;
            end
            PH_BIT_B: begin
              scl_nxt = 1'b1;
              delay_count_nxt = delay_start;
              phase_nxt = PH_BIT_C;
            end
            PH_BIT_C: begin
              scl_nxt = 1'b0;
              delay_count_nxt = delay_start;
              bit_count_nxt = bit_inc;
              phase_nxt = bit_inc[3] ? PH_ACK_A : PH_BIT_A;
            end
            PH_ACK_A: begin
              sda_nxt = 1'b1;
              poll_count_nxt = 8'd0;
              delay_count_nxt = delay_start;
              phase_nxt = PH_ACK_B;
            end
            PH_ACK_B: begin
              scl_nxt = 1'b1;
              delay_count_nxt = delay_start;
              phase_nxt = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
              if (!in_sda_sample) begin
                scl_nxt        = 1'b0;
                byte_slot_nxt  = nb_slot;
                shift_byte_nxt = nb_shift;
                bit_count_nxt  = nb_bit;
                phase_nxt      = nb_phase;
              end else if (poll_count_r >= ack_timeout_r) begin
                miss_flag_nxt = 1'b1;
                phase_nxt     = PH_SP_A;
              end else begin
                poll_count_nxt  = poll_count_r + 8'd1;
                delay_count_nxt = delay_start;
              end
            end
            PH_SP_A: begin
              sda_nxt = 1'b0;
              phase_nxt = PH_SP_B;
            end
            PH_SP_B: begin
              scl_nxt = 1'b1;
              delay_count_nxt = delay_start;
              phase_nxt = PH_SP_C;
            end
            PH_SP_C: begin
              sda_nxt = 1'b1;
              delay_count_nxt = delay_start;
              phase_nxt = PH_SP_END;
            end
            PH_SP_END: begin
              if (byte_slot_r == SLOT_STOP) begin
                done      = 1'b1;
                phase_nxt = PH_IDLE;
              end else begin
                byte_slot_nxt  = nb_slot;
                shift_byte_nxt = nb_shift;
                bit_count_nxt  = nb_bit;
                phase_nxt      = nb_phase;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
      end
    end
  end

  // Result for the accepted item and output valid
  always_comb begin
    res_nxt.scl_level  = scl_nxt;
    res_nxt.sda_level  = sda_nxt;
    res_nxt.busy_res   = (phase_nxt != PH_IDLE);
    res_nxt.ack_missed = miss_flag_nxt;
    res_nxt.done_res   = done;
    res_nxt.rejected   = rej;
    out_valid_nxt      = in_acc || (out_valid_r && out_stall);
  end

  // Configuration registers; writes outside the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      device_address_r    <= DEVICE_ADDRESS_RST;
      ack_timeout_r       <= ACK_TIMEOUT_RST;
      half_period_ticks_r <= HALF_PERIOD_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS:    device_address_r    <= cfg_data;
        REG_ACK_TIMEOUT:       ack_timeout_r       <= cfg_data;
        REG_HALF_PERIOD_TICKS: half_period_ticks_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      byte_slot_r    <= 2'd0;
      bit_count_r    <= 4'd0;
      shift_byte_r   <= 8'd0;
      held_payload_r <= 8'd0;
      held_kind_r    <= 1'b0;
      delay_count_r  <= 8'd0;
      poll_count_r   <= 8'd0;
      miss_flag_r    <= 1'b0;
      scl_r          <= 1'b1;
      sda_r          <= 1'b1;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      byte_slot_r    <= byte_slot_nxt;
      bit_count_r    <= bit_count_nxt;
      shift_byte_r   <= shift_byte_nxt;
      held_payload_r <= held_payload_nxt;
      held_kind_r    <= held_kind_nxt;
      delay_count_r  <= delay_count_nxt;
      poll_count_r   <= poll_count_nxt;
      miss_flag_r    <= miss_flag_nxt;
      scl_r          <= scl_nxt;
      sda_r          <= sda_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_scl_level  = res_r.scl_level;
  assign out_sda_level  = res_r.sda_level;
  assign out_busy_res   = res_r.busy_res;
  assign out_ack_missed = res_r.ack_missed;
  assign out_done_res   = res_r.done_res;
  assign out_rejected   = res_r.rejected;

  // Checks
  `IDBW_ASSERT(a_stall_only_when_full, clk, rst_n, in_stall |-> out_valid_r, "input stalled with empty output register")
  `IDBW_ASSERT(a_reject_keeps_phase, clk, rst_n, (in_acc && !in_req_type && phase_r != PH_IDLE) |=> (out_rejected && $stable(phase_r)), "rejected request moved the sequencer")
  `IDBW_ASSERT(a_done_goes_idle, clk, rst_n, (in_acc && in_req_type && phase_r == PH_SP_END && delay_count_r == 8'd0 && byte_slot_r == SLOT_STOP) |=> (phase_r == PH_IDLE && out_done_res && !out_busy_res), "final STOP did not complete")
  `IDBW_ASSERT(a_idle_no_delay, clk, rst_n, (phase_r == PH_IDLE) |-> (delay_count_r == 8'd0), "delay pending while idle")

endmodule

### test/tb_top.sv
// Self-checking testbench for the i2c_display_byte_writer I2C write master.
// Depends on idbw_pkg and the i2c_display_byte_writer RTL; a scoreboard class
// predicts the pin sequence per item and checks every result transfer.
module tb_top;
  import idbw_pkg::*;

  // Item kinds on the input channel
  localparam logic REQ_SEND = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 180;
  localparam int MAX_PRINTS   = 40;
  localparam int SETTLE_WAIT  = 20;

  // Pin-sequence predictor plus the queue of results still due
  class i2c_write_checker;
    logic [7:0] dev_addr;
    logic [7:0] ack_limit;
    logic [7:0] half_period;
    logic [3:0] phase;
    logic [1:0] slot;
    logic [3:0] bits_sent;
    logic [7:0] shift_reg;
    logic [7:0] held_byte;
    logic       held_is_data;
    logic [7:0] delay_left;
    logic [7:0] polls;
    logic       miss;
    logic       scl;
    logic       sda;
    res_t       pins_due[$];
    int         errors;
    int         results_seen;

    function new();
      dev_addr     = DEVICE_ADDRESS_RST;
      ack_limit    = ACK_TIMEOUT_RST;
      half_period  = HALF_PERIOD_TICKS_RST;
      phase        = PH_IDLE;
      slot         = '0;
      bits_sent    = '0;
      shift_reg    = '0;
      held_byte    = '0;
      held_is_data = 1'b0;
      delay_left   = '0;
      polls        = '0;
      miss         = 1'b0;
      scl          = 1'b1;
      sda          = 1'b1;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        REG_DEVICE_ADDRESS:    dev_addr = val;
        REG_ACK_TIMEOUT:       ack_limit = val;
        REG_HALF_PERIOD_TICKS: half_period = val;
        default: ;
      endcase
    endfunction

    function bit busy();
      return phase != PH_IDLE;
    endfunction

    // A zero half period counts as one tick
    function void arm_delay();
      delay_left = (half_period == 8'd0) ? 8'd0 : half_period - 8'd1;
    endfunction

    function void next_byte();
      if (slot < 2'd2) begin
        slot = slot + 2'd1;
        shift_reg = (slot == 2'd1) ? (held_is_data ? CTRL_DATA : CTRL_CMD) : held_byte;
        bits_sent = '0;
        phase = PH_BIT_A;
      end else begin
        slot = SLOT_STOP;
        phase = PH_SP_A;
      end
    endfunction

    // One tick: burn a delay tick or take the next pin action
    function bit pin_step(logic smp);
      bit done;
      done = 1'b0;
      if (phase == PH_IDLE)
        return 1'b0;
      if (delay_left != 8'd0) begin
        delay_left = delay_left - 8'd1;
        return 1'b0;
      end
      case (phase)
        PH_ST_A: begin
          sda = 1'b1;
          scl = 1'b1;
          arm_delay();
          phase = PH_ST_B;
        end
        PH_ST_B: begin
          sda = 1'b0;
          arm_delay();
          phase = PH_ST_C;
        end
        PH_ST_C: begin
          scl = 1'b0;
          phase = PH_BIT_A;
        end
        PH_BIT_A: begin
          sda = shift_reg[7];
          shift_reg = {shift_reg[6:0], 1'b0};
          phase = PH_BIT_B;
        end
        PH_BIT_B: begin
          scl = 1'b1;
          arm_delay();
          phase = PH_BIT_C;
        end
        PH_BIT_C: begin
          scl = 1'b0;
          arm_delay();
          bits_sent = bits_sent + 4'd1;
          phase = (bits_sent >= 4'd8) ? PH_ACK_A : PH_BIT_A;
        end
        PH_ACK_A: begin
          sda = 1'b1;
          polls = '0;
          arm_delay();
          phase = PH_ACK_B;
        end
        PH_ACK_B: begin
          scl = 1'b1;
          arm_delay();
          phase = PH_ACK_POLL;
        end
        PH_ACK_POLL: begin
          if (smp == 1'b0) begin
            scl = 1'b0;
            next_byte();
          end else if (polls >= ack_limit) begin
            miss = 1'b1;
            phase = PH_SP_A;
          end else begin
            polls = polls + 8'd1;
            arm_delay();
          end
        end
        PH_SP_A: begin
          sda = 1'b0;
          phase = PH_SP_B;
        end
        PH_SP_B: begin
          scl = 1'b1;
          arm_delay();
          phase = PH_SP_C;
        end
        PH_SP_C: begin
          sda = 1'b1;
          arm_delay();
          phase = PH_SP_END;
        end
        PH_SP_END: begin
          if (slot >= SLOT_STOP) begin
            done = 1'b1;
            phase = PH_IDLE;
          end else begin
            next_byte();
          end
        end
        default: phase = PH_IDLE;
      endcase
      return done;
    endfunction

    // Called once per accepted input transfer
    function void predict_item(logic req, logic [7:0] pay, logic kind, logic smp);
      res_t r;
      logic rej;
      logic done;
      rej  = 1'b0;
      done = 1'b0;
      if (req == REQ_SEND) begin
        if (phase != PH_IDLE) begin
          rej = 1'b1;
        end else begin
          held_byte    = pay;
          held_is_data = kind;
          miss         = 1'b0;
          slot         = '0;
          bits_sent    = '0;
          shift_reg    = dev_addr;
          delay_left   = '0;
          polls        = '0;
          phase        = PH_ST_A;
        end
      end else begin
        done = pin_step(smp);
      end
      r.scl_level  = scl;
      r.sda_level  = sda;
      r.busy_res   = (phase != PH_IDLE);
      r.ack_missed = miss;
      r.done_res   = done;
      r.rejected   = rej;
      pins_due.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("mismatch on result %0d: %s", results_seen, what);
    endtask

    task check_result(res_t got);
      res_t  want;
      string field_names[6];
      field_names = '{"scl_level", "sda_level", "busy_res", "ack_missed", "done_res",
                      "rejected"};
      results_seen++;
      if (pins_due.size() == 0) begin
        report("result transfer with nothing pending");
        return;
      end
      want = pins_due.pop_front();
      for (int i = 0; i < 6; i++)
        if (got[5-i] !== want[5-i])
          report($sformatf("%s got %0b want %0b", field_names[i], got[5-i], want[5-i]));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_req_type = 1'b0;
  logic [7:0] in_payload = 8'h00;
  logic       in_is_data = 1'b0;
  logic       in_sda_sample = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_scl_level;
  logic       out_sda_level;
  logic       out_busy_res;
  logic       out_ack_missed;
  logic       out_done_res;
  logic       out_rejected;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 2'd0;
  logic [7:0] cfg_data = 8'h00;

  i2c_write_checker sb;
  int send_gap_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int pressure_reqs = 0;
  int pressure_seen = 0;
  int hold_left = 0;
  int cycle_count;

  i2c_display_byte_writer DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_payload    (in_payload),
    .in_is_data    (in_is_data),
    .in_sda_sample (in_sda_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_scl_level (out_scl_level),
    .out_sda_level (out_sda_level),
    .out_busy_res  (out_busy_res),
    .out_ack_missed(out_ack_missed),
    .out_done_res  (out_done_res),
    .out_rejected  (out_rejected),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Result side: random stall, or a long hold-off on request
  always @(negedge clk) begin
    if (pressure_reqs != pressure_seen) begin
      pressure_seen = pressure_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Check every result transfer
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result({out_scl_level, out_sda_level, out_busy_res, out_ack_missed,
                       out_done_res, out_rejected});
  end

  // Offer one item, with random idle cycles ahead of it; returns after the transfer
  task automatic send_item(logic req, logic [7:0] pay, logic kind, logic smp);
    while ($urandom_range(99) < send_gap_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_payload    <= pay;
    in_is_data    <= kind;
    in_sda_sample <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.predict_item(req, pay, kind, smp);
    items_sent++;
  endtask

  task automatic send_tick(int high_pct);
    send_item(REQ_TICK, 8'($urandom_range(255)), 1'($urandom_range(1)),
              $urandom_range(99) < high_pct);
  endtask

  task automatic tick_until_idle(int high_pct);
    while (sb.busy()) send_tick(high_pct);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pins_due.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Finish any open transaction with clean acks, then reprogram all registers
  task automatic reconfigure(logic [7:0] addr, logic [7:0] ack_to, logic [7:0] hp);
    tick_until_idle(0);
    drain_results();
    cfg_write(REG_DEVICE_ADDRESS, addr);
    cfg_write(REG_ACK_TIMEOUT, ack_to);
    cfg_write(REG_HALF_PERIOD_TICKS, hp);
  endtask

  // One send request followed by a random run of ticks; stray requests mixed in
  task automatic run_transaction();
    int high_pct;
    int full_ticks;
    int n_ticks;
    int eff_hp;
    case ($urandom_range(3))
      0, 1: high_pct = 0;
      2: high_pct = 20;
      default: high_pct = 50;
    endcase
    eff_hp = (sb.half_period == 8'd0) ? 1 : sb.half_period;
    full_ticks = 60 * eff_hp + 40;
    if ($urandom_range(99) < 70)
      n_ticks = full_ticks + $urandom_range(30);
    else
      n_ticks = $urandom_range(full_ticks);
    send_item(REQ_SEND, 8'($urandom_range(255)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    for (int k = 0; k < n_ticks; k++) begin
      if ($urandom_range(99) < 3)
        send_item(REQ_SEND, 8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
      else
        send_tick(high_pct);
    end
  endtask

  task automatic random_phase(int gap, int stall, int n_items);
    int target;
    target = items_sent + n_items;
    send_gap_pct = gap;
    stall_pct = stall;
    while (items_sent < target) run_transaction();
  endtask

  // Run limit
  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Ticks while idle show the resting pins
    send_item(REQ_TICK, 8'h00, 1'b0, 1'b0);
    send_item(REQ_TICK, 8'hFF, 1'b1, 1'b1);

    // Command byte 0x00 with clean acks; requests while busy are rejected
    send_item(REQ_SEND, 8'h00, 1'b0, 1'b0);
    send_item(REQ_SEND, 8'hA5, 1'b1, 1'b1);
    repeat (5) send_tick(0);
    send_item(REQ_SEND, 8'hFF, 1'b1, 1'b0);
    tick_until_idle(0);

    // Data byte 0xFF, zero timeout and zero half period, no acknowledge at all:
    // every byte misses, the payload miss is followed by the final STOP
    reconfigure(8'h78, 8'd0, 8'd0);
    send_item(REQ_SEND, 8'hFF, 1'b1, 1'b0);
    tick_until_idle(100);

    // Registers change in mid transaction; the address is already captured
    reconfigure(8'hFF, 8'd255, 8'd2);
    send_item(REQ_SEND, 8'h5A, 1'b1, 1'b0);
    repeat (10) send_tick(0);
    drain_results();
    cfg_write(REG_DEVICE_ADDRESS, 8'h00);
    cfg_write(REG_HALF_PERIOD_TICKS, 8'd3);
    tick_until_idle(30);

    // Longer pin delays
    reconfigure(8'h3C, 8'd1, 8'd6);
    send_item(REQ_SEND, 8'hC3, 1'b0, 1'b0);
    tick_until_idle(0);

    // Random transactions; the receiver holds off once while items keep coming
    reconfigure(8'($urandom_range(255)), 8'($urandom_range(100, 255)), 8'd1);
    pressure_reqs++;
    random_phase(0, 0, PHASE_ITEMS);
    reconfigure(8'($urandom_range(255)), 8'd0, 8'd0);
    random_phase(78, 0, PHASE_ITEMS);
    reconfigure(8'($urandom_range(255)), 8'd2, 8'd2);
    random_phase(0, 78, PHASE_ITEMS);
    reconfigure(8'($urandom_range(255)), 8'd1, 8'd1);
    random_phase(15, 15, PHASE_ITEMS);

    drain_results();
    repeat (SETTLE_WAIT) @(posedge clk);
    if (sb.errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
